### sv/i2cm_pkg.sv
`timescale 1ns / 1ps
package i2cm_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd1;

	localparam logic [7:0]  PHASE_TICKS_RST   = 8'd10;
	localparam logic [7:0]  TIMEOUT_LIMIT_RST = 8'd255;
	localparam logic [7:0]  MSB_MASK          = 8'h80;
	localparam logic [7:0]  STRETCH_MAX       = 8'hFF;
	localparam logic [15:0] FAIL_MAX          = 16'hFFFF;
	localparam logic [3:0]  DATA_BITS         = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_SETUP = 4'd1,
		PH_WAIT  = 4'd2,
		PH_HIGH  = 4'd3,
		PH_SDALO = 4'd4,
		PH_LOW   = 4'd5,
		PH_END   = 4'd6
	} phase_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       scl_in;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       scl_in;
		logic       sda_in;
	} cls_item_t;

	typedef struct packed {
		logic        scl_pull_low;
		logic        sda_pull_low;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  rx_byte;
		logic        ack_seen;
		logic        timed_out;
		logic [15:0] fail_total;
	} out_item_t;

endpackage

### sv/i2cm_front.sv
`timescale 1ns / 1ps
module i2cm_front import i2cm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      push_valid,
	input  logic      push_ready,
	output cls_item_t push_data
);

	logic      valid_s1;
	cls_item_t item_s1;
	cls_item_t cls;

	always_comb begin
		cls.tx_byte     = in_data.tx_byte;
		cls.ack_to_send = in_data.ack_to_send;
		cls.scl_in      = in_data.scl_in;
		cls.sda_in      = in_data.sda_in;
		unique case (in_data.cmd)
			CMD_START: cls.cmd = CMD_START;
			CMD_STOP:  cls.cmd = CMD_STOP;
			CMD_WRITE: cls.cmd = CMD_WRITE;
			CMD_READ:  cls.cmd = CMD_READ;
			default:   cls.cmd = CMD_NONE;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

### sv/i2cm_queue.sv
`timescale 1ns / 1ps
module i2cm_queue import i2cm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  cls_item_t push_data,
	output logic      pop_valid,
	input  logic      pop,
	output cls_item_t pop_data
);

	cls_item_t   mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/i2cm_back.sv
`timescale 1ns / 1ps
module i2cm_back import i2cm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  cls_item_t            q_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata
);

	logic [7:0]  phase_ticks_q, timeout_limit_q;
	phase_t      phase_q, phase_d;
	cmd_t        act_q, act_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  hold_q, hold_d;
	logic [7:0]  stretch_q, stretch_d;
	logic        ack_q, ack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic [15:0] fail_q, fail_d;
	logic        done, tout;
	logic        step;
	logic [7:0]  hold_load;
	logic        hold_end;
	out_item_t   res;
	logic        out_valid_q;
	out_item_t   out_data_q;

	assign step      = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = step;
	assign hold_load = (phase_ticks_q != 8'd0) ? phase_ticks_q : 8'd1;
	assign hold_end  = (hold_q <= 8'd1);

	always_comb begin
		logic [3:0] nb;
		logic [7:0] sn;
		nb        = bit_q + 4'd1;
		sn        = (stretch_q != STRETCH_MAX) ? stretch_q + 8'd1 : stretch_q;
		phase_d   = phase_q;
		act_d     = act_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		hold_d    = hold_q;
		stretch_d = stretch_q;
		ack_d     = ack_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		fail_d    = fail_q;
		done      = 1'b0;
		tout      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (q_data.cmd != CMD_NONE) begin
					act_d   = q_data.cmd;
					bit_d   = 4'd0;
					phase_d = PH_SETUP;
					hold_d  = hold_load;
					unique case (q_data.cmd)
						CMD_START: sda_d = 1'b0;
						CMD_STOP:  sda_d = 1'b1;
						CMD_WRITE: begin
							shift_d = q_data.tx_byte;
							sda_d   = ((q_data.tx_byte & MSB_MASK) == 8'd0);
						end
						default: begin
							shift_d = 8'd0;
							ack_d   = q_data.ack_to_send;
							sda_d   = 1'b0;
						end
					endcase
				end
			end
			PH_SETUP: begin
				if (hold_end) begin
					scl_d     = 1'b0;
					stretch_d = 8'd0;
					phase_d   = PH_WAIT;
				end else begin
					hold_d = hold_q - 8'd1;
				end
			end
			PH_WAIT: begin
				if (q_data.scl_in) begin
					if (act_q == CMD_WRITE) begin
						if (bit_q < DATA_BITS) begin
							shift_d = {shift_q[6:0], 1'b0};
						end else begin
							ack_d = q_data.sda_in;
						end
					end else if (act_q == CMD_READ && bit_q < DATA_BITS) begin
						shift_d = {shift_q[6:0], q_data.sda_in};
					end
					phase_d = PH_HIGH;
					hold_d  = hold_load;
				end else begin
					stretch_d = sn;
					if (sn >= timeout_limit_q) begin
						if (fail_q != FAIL_MAX) begin
							fail_d = fail_q + 16'd1;
						end
						tout    = 1'b1;
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_HIGH: begin
				if (hold_end) begin
					hold_d = hold_load;
					if (act_q == CMD_START) begin
						sda_d   = 1'b1;
						phase_d = PH_SDALO;
					end else if (act_q == CMD_STOP) begin
						sda_d   = 1'b0;
						phase_d = PH_END;
					end else begin
						scl_d   = 1'b1;
						phase_d = PH_LOW;
					end
				end else begin
					hold_d = hold_q - 8'd1;
				end
			end
			PH_SDALO: begin
				if (hold_end) begin
					scl_d   = 1'b1;
					hold_d  = hold_load;
					phase_d = PH_END;
				end else begin
					hold_d = hold_q - 8'd1;
				end
			end
			PH_LOW: begin
				if (hold_end) begin
					bit_d = nb;
					if (nb < DATA_BITS) begin
						sda_d   = (act_q == CMD_WRITE) ? ((shift_q & MSB_MASK) == 8'd0) : 1'b0;
						hold_d  = hold_load;
						phase_d = PH_SETUP;
					end else if (nb == DATA_BITS) begin
						sda_d   = (act_q == CMD_WRITE) ? 1'b0 : !ack_q;
						hold_d  = hold_load;
						phase_d = PH_SETUP;
					end else begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
				end else begin
					hold_d = hold_q - 8'd1;
				end
			end
			PH_END: begin
				if (hold_end) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					hold_d = hold_q - 8'd1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		res.scl_pull_low = scl_d;
		res.sda_pull_low = sda_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.done_res     = done;
		res.rx_byte      = (done && !tout && act_d == CMD_READ) ? shift_d : 8'd0;
		res.ack_seen     = done && (act_d == CMD_WRITE) && (tout || ack_d);
		res.timed_out    = tout;
		res.fail_total   = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q   <= PHASE_TICKS_RST;
			timeout_limit_q <= TIMEOUT_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PHASE_TICKS) begin
				phase_ticks_q <= cfg_wdata;
			end else if (cfg_index == CFG_TIMEOUT_LIMIT) begin
				timeout_limit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			act_q     <= CMD_NONE;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			hold_q    <= 8'd0;
			stretch_q <= 8'd0;
			ack_q     <= 1'b1;
			scl_q     <= 1'b0;
			sda_q     <= 1'b0;
			fail_q    <= 16'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			act_q     <= act_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			hold_q    <= hold_d;
			stretch_q <= stretch_d;
			ack_q     <= ack_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			fail_q    <= fail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### sv/i2c_master_byte_engine_core.sv
`timescale 1ns / 1ps
// I2C master byte engine, open drain, advanced one tick per input transfer.
// in channel (in_valid/in_ready/in_data): one tick each, carrying the sampled
//   SCL/SDA levels and, while idle, a command (start, stop, write, read).
// out channel (out_valid/out_ready/out_data): exactly one result per tick,
//   in order: line drives, busy/done, read byte, ack, timeout, fail count.
// cfg port (cfg_we/cfg_index/cfg_wdata): index 0 phase_ticks, 1 timeout_limit;
//   write only while no tick is in flight.
// Path: the front register loads at the input transfer, the queue takes the
//   item from the front register, and the engine step writes the result into
//   the output register.
// Throughput: one tick per cycle; the engine steps once per cycle whenever
//   the output register is empty or being taken.
// Receiver stall: the output register holds, the engine stops, the queue fills
//   (two entries), the front register holds and then in_ready drops.
// Reset: both lines released, engine idle, registers at 10 and 255, fail
//   count zero, no results pending.
module i2c_master_byte_engine_core import i2cm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata
);

	logic      push_valid, push_ready;
	cls_item_t push_data;
	logic      q_valid, q_pop;
	cls_item_t q_data;

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule

### sv/i2cm_checker.sv
`timescale 1ns / 1ps
module i2cm_checker import i2cm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done reported while still busy");

	a_tout_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.timed_out || out_data.ack_seen) |-> out_data.done_res)
		else $error("timeout or ack flag outside a done tick");

	a_rx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.rx_byte != 8'd0) |-> out_data.done_res && !out_data.timed_out)
		else $error("read byte shown outside a clean done tick");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
import i2cm_pkg::*;

class engine_scoreboard;
	logic [7:0]  tick_len = PHASE_TICKS_RST;
	logic [7:0]  tmo_limit = TIMEOUT_LIMIT_RST;
	phase_t      phase = PH_IDLE;
	logic [2:0]  act_cmd = CMD_NONE;
	logic [3:0]  bit_cnt = '0;
	logic [7:0]  shreg = '0;
	logic [7:0]  hold = '0;
	logic [7:0]  stretch = '0;
	logic        ack_bit = 1'b1;
	logic        scl_drv = 1'b0;
	logic        sda_drv = 1'b0;
	logic [15:0] fails = '0;
	out_item_t   line_results[$];
	int          n_err = 0;
	int          n_checked = 0;
	int          n_done = 0;
	int          n_tout = 0;

	task report(string msg);
		n_err++;
		if (n_err <= 25) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		case (idx)
			CFG_PHASE_TICKS: tick_len = val;
			CFG_TIMEOUT_LIMIT: tmo_limit = val;
			default: ;
		endcase
	endfunction

	function void start_hold(phase_t p);
		phase = p;
		hold = (tick_len != 0) ? tick_len : 8'd1;
	endfunction

	function bit hold_done();
		if (hold > 1) begin
			hold--;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the engine by one accepted tick and queue the line/status it must show
	function void note_tick(in_item_t it);
		logic [4:0] nb;
		logic done, tout;
		out_item_t res;
		done = 1'b0;
		tout = 1'b0;
		case (phase)
			PH_IDLE: begin
				if (it.cmd >= CMD_START && it.cmd <= CMD_READ) begin
					act_cmd = it.cmd;
					bit_cnt = '0;
					case (it.cmd)
						CMD_START: sda_drv = 1'b0;
						CMD_STOP: sda_drv = 1'b1;
						CMD_WRITE: begin
							shreg = it.tx_byte;
							sda_drv = (it.tx_byte & MSB_MASK) == 0;
						end
						default: begin
							shreg = '0;
							ack_bit = it.ack_to_send;
							sda_drv = 1'b0;
						end
					endcase
					start_hold(PH_SETUP);
				end
			end
			PH_SETUP: begin
				if (hold_done()) begin
					scl_drv = 1'b0;
					stretch = '0;
					phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (it.scl_in) begin
					if (act_cmd == CMD_WRITE) begin
						if (bit_cnt < DATA_BITS) shreg = shreg << 1;
						else ack_bit = it.sda_in;
					end else if (act_cmd == CMD_READ && bit_cnt < DATA_BITS) begin
						shreg = {shreg[6:0], it.sda_in};
					end
					start_hold(PH_HIGH);
				end else begin
					if (stretch < STRETCH_MAX) stretch++;
					if (stretch >= tmo_limit) begin
						if (fails < FAIL_MAX) fails++;
						tout = 1'b1;
						done = 1'b1;
						phase = PH_IDLE;
					end
				end
			end
			PH_HIGH: begin
				if (hold_done()) begin
					if (act_cmd == CMD_START) begin
						sda_drv = 1'b1;
						start_hold(PH_SDALO);
					end else if (act_cmd == CMD_STOP) begin
						sda_drv = 1'b0;
						start_hold(PH_END);
					end else begin
						scl_drv = 1'b1;
						start_hold(PH_LOW);
					end
				end
			end
			PH_SDALO: begin
				if (hold_done()) begin
					scl_drv = 1'b1;
					start_hold(PH_END);
				end
			end
			PH_LOW: begin
				if (hold_done()) begin
					nb = {1'b0, bit_cnt} + 5'd1;
					bit_cnt = nb[3:0];
					if (nb < DATA_BITS) begin
						sda_drv = (act_cmd == CMD_WRITE) ? ((shreg & MSB_MASK) == 0) : 1'b0;
						start_hold(PH_SETUP);
					end else if (nb == DATA_BITS) begin
						sda_drv = (act_cmd == CMD_WRITE) ? 1'b0 : !ack_bit;
						start_hold(PH_SETUP);
					end else begin
						done = 1'b1;
						phase = PH_IDLE;
					end
				end
			end
			PH_END: begin
				if (hold_done()) begin
					done = 1'b1;
					phase = PH_IDLE;
				end
			end
			default: phase = PH_IDLE;
		endcase
		res.scl_pull_low = scl_drv;
		res.sda_pull_low = sda_drv;
		res.busy_res = (phase != PH_IDLE);
		res.done_res = done;
		res.rx_byte = (done && !tout && act_cmd == CMD_READ) ? shreg : 8'd0;
		res.ack_seen = (done && act_cmd == CMD_WRITE) ? (tout | ack_bit) : 1'b0;
		res.timed_out = tout;
		res.fail_total = fails;
		line_results.push_back(res);
		n_done += int'(done);
		n_tout += int'(tout);
	endfunction

	task cmp_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			report($sformatf("tick result %0d: %s is %0h, expected %0h", n_checked, name, got,
				want));
		end
	endtask

	task check_tick(out_item_t got);
		out_item_t want;
		if (line_results.size() == 0) begin
			report("tick result with no tick pending");
			return;
		end
		want = line_results.pop_front();
		n_checked++;
		cmp_field("scl_pull_low", 16'(got.scl_pull_low), 16'(want.scl_pull_low));
		cmp_field("sda_pull_low", 16'(got.sda_pull_low), 16'(want.sda_pull_low));
		cmp_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
		cmp_field("done_res", 16'(got.done_res), 16'(want.done_res));
		cmp_field("rx_byte", 16'(got.rx_byte), 16'(want.rx_byte));
		cmp_field("ack_seen", 16'(got.ack_seen), 16'(want.ack_seen));
		cmp_field("timed_out", 16'(got.timed_out), 16'(want.timed_out));
		cmp_field("fail_total", got.fail_total, want.fail_total);
	endtask
endclass

module tb_top;
	localparam int STUCK_LIMIT = 500;
	localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [2:0] CMD_BAD_LAST = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_wdata = '0;

	engine_scoreboard sb;
	int stuck_cycles = 0;
	bit calm = 1'b0;
	bit hammer = 1'b0;
	int stretch_left = 0;
	bit last_scl_low = 1'b0;
	int in_quiet = 0;
	int n_ticks = 0;
	int n_settings = 1;

	i2c_master_byte_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial sb = new();

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
		else stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
		$display("status: fail");
		$finish;
	end

	// bus seen by the engine: open-drain lines, slave data, clock stretching, some glitches
	function automatic in_item_t line_tick(input logic [2:0] c, input logic [7:0] tx,
			input logic ack);
		in_item_t it;
		it.cmd = c;
		it.tx_byte = tx;
		it.ack_to_send = ack;
		if (!sb.scl_drv && last_scl_low && stretch_left == 0 && $urandom_range(0, 9) == 0)
			stretch_left = $urandom_range(1, 12);
		last_scl_low = sb.scl_drv;
		if (hammer || sb.scl_drv) begin
			it.scl_in = 1'b0;
		end else if (stretch_left > 0) begin
			it.scl_in = 1'b0;
			stretch_left--;
		end else begin
			it.scl_in = 1'b1;
		end
		it.sda_in = sb.sda_drv ? 1'b0 : 1'($urandom_range(0, 1));
		if (!hammer && stretch_left == 0 && $urandom_range(0, 31) == 0) begin
			it.scl_in = 1'($urandom_range(0, 1));
			it.sda_in = 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	function automatic logic [2:0] pick_cmd();
		int r;
		if (sb.phase != PH_IDLE) return 3'($urandom_range(0, 7));
		r = $urandom_range(0, 19);
		if (r == 0) return CMD_NONE;
		if (r == 1) return 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
		return 3'($urandom_range(CMD_START, CMD_READ));
	endfunction

	task automatic send_tick(input in_item_t it);
		if (in_quiet > 0) begin
			in_quiet--;
		end else if (!calm && $urandom_range(0, 99) == 0) begin
			in_quiet = $urandom_range(40, 300);
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(it);
		n_ticks++;
	endtask

	// issue one command on an idle tick and clock the engine until it is idle again
	task automatic run_cmd(input logic [2:0] c, input logic [7:0] tx, input logic ack);
		send_tick(line_tick(c, tx, ack));
		while (sb.phase != PH_IDLE) begin
			send_tick(line_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom)));
		end
	endtask

	task automatic run_random(input int n);
		int busy_ticks;
		logic [2:0] c;
		busy_ticks = 0;
		while (busy_ticks < n || sb.phase != PH_IDLE) begin
			c = pick_cmd();
			if (sb.phase != PH_IDLE || (c >= CMD_START && c <= CMD_READ)) busy_ticks++;
			send_tick(line_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.line_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [7:0] ticks, input logic [7:0] limit);
		settle();
		write_reg(CFG_PHASE_TICKS, ticks);
		write_reg(CFG_TIMEOUT_LIMIT, limit);
		stretch_left = 0;
		n_settings++;
	endtask

	initial begin
		int stall, quiet;
		bit rdy;
		stall = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_tick(out_data);
			if (calm || quiet > 0) begin
				rdy = 1'b1;
				if (quiet > 0) quiet--;
			end else if (stall > 0) begin
				rdy = 1'b0;
				stall--;
			end else if ($urandom_range(0, 99) == 0) begin
				quiet = $urandom_range(40, 300);
				rdy = 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	initial begin
		int c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unknown codes, start, a full write, stop
		run_cmd(CMD_NONE, 8'h00, 1'b0);
		for (c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++) run_cmd(3'(c), 8'hFF, 1'b1);
		run_cmd(CMD_START, 8'h00, 1'b0);
		run_cmd(CMD_WRITE, 8'hFF, 1'b0);
		run_cmd(CMD_STOP, 8'h00, 1'b0);
		// slave holds SCL past the limit, then stop with SCL left released
		stretch_left = 300;
		run_cmd(CMD_WRITE, 8'h80, 1'b0);
		run_cmd(CMD_STOP, 8'h00, 1'b0);

		// zero hold and zero timeout
		configure(8'd0, 8'd0);
		run_cmd(CMD_START, 8'h00, 1'b0);
		stretch_left = 1;
		run_cmd(CMD_WRITE, 8'h7F, 1'b0);
		run_random(80);

		configure(8'd1, 8'd255);
		run_random(160);
		configure(8'd1, 8'd4);
		run_random(90);
		configure(8'd2, 8'd1);
		run_random(80);
		configure(8'd3, 8'd8);
		run_random(80);
		configure(8'd7, 8'd20);
		run_random(80);

		// no idling from here on: longest hold, then back to back timeouts
		calm = 1'b1;
		configure(8'd255, 8'd1);
		hammer = 1'b1;
		run_cmd(CMD_WRITE, 8'($urandom), 1'b0);
		configure(8'd0, 8'd0);
		repeat (40) run_cmd(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom), 1'($urandom));
		hammer = 1'b0;
		configure(8'd1, 8'd6);
		run_random(50);

		settle();
		if (sb.line_results.size() != 0) begin
			sb.report($sformatf("%0d tick results never arrived", sb.line_results.size()));
		end
		$display("covered %0d ticks over %0d register settings: %0d commands done, %0d timed out",
			n_ticks, n_settings, sb.n_done, sb.n_tout);
		$display("checked %0d tick results, %0d mismatches, fail counter ended at %0d",
			sb.n_checked, sb.n_err, sb.fails);
		if (sb.n_err == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
